### design/sha256_pkg.sv
// shared types, constants and round functions of the sha-256 stream hasher
package sha256_pkg;

  localparam int SHA_QUEUE_DEPTH = 2;

  localparam int BLOCK_BITS = 512;
  localparam int TOTAL_BITS = 61;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [BLOCK_BITS-1:0] data;
    logic                  last;
  } block_t;

  typedef struct packed {
    logic   push;
    block_t entry;
  } push_t;

  typedef enum logic [1:0] {
    FRONT_DATA,
    FRONT_MARK,
    FRONT_ZERO,
    FRONT_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINISH
  } core_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### design/sha256_front.sv
// front end: collects message bytes into blocks and generates the padding
module sha256_front import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  message_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        q_full,
  output push_t       push
);

  front_state_t          state, state_next;
  logic [BLOCK_BITS-1:0] blk;
  logic [5:0]            pos;
  logic [TOTAL_BITS-1:0] total;
  logic [63:0]           len;

  logic                  accept;
  logic                  emit;
  logic                  wr_en;
  logic [7:0]            wr_byte;
  logic [5:0]            pos_inc;
  logic [TOTAL_BITS-1:0] total_inc;

  assign accept    = msg_valid && !msg_stall;
  assign pos_inc   = pos + 6'd1;
  assign total_inc = total + TOTAL_BITS'(byte_present);
  // a byte that closes a block needs room in the queue
  assign emit      = !((pos == LAST_POS) && q_full);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FRONT_DATA: begin
        if (accept && end_of_message) state_next = FRONT_MARK;
      end
      FRONT_MARK: begin
        if (emit) state_next = (pos_inc == LEN_POS) ? FRONT_LEN : FRONT_ZERO;
      end
      FRONT_ZERO: begin
        if (emit && pos_inc == LEN_POS) state_next = FRONT_LEN;
      end
      FRONT_LEN: begin
        if (emit && pos == LAST_POS) state_next = FRONT_DATA;
      end
      default: state_next = FRONT_DATA;
    endcase
  end

  // outputs
  always_comb begin
    msg_stall = 1'b1;
    wr_en     = 1'b0;
    wr_byte   = 8'h00;
    case (state)
      FRONT_DATA: begin
        msg_stall = q_full;
        wr_en     = accept && byte_present;
        wr_byte   = message_byte;
      end
      FRONT_MARK: begin
        wr_en   = emit;
        wr_byte = PAD_MARK;
      end
      FRONT_ZERO: begin
        wr_en   = emit;
        wr_byte = 8'h00;
      end
      FRONT_LEN: begin
        wr_en   = emit;
        wr_byte = len[63:56];
      end
      default: begin
        msg_stall = 1'b1;
      end
    endcase
    push.push       = wr_en && (pos == LAST_POS);
    push.entry.data = {blk[BLOCK_BITS-9:0], wr_byte};
    push.entry.last = (state == FRONT_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_DATA;
      pos   <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      if (wr_en) pos <= pos_inc;
      if (accept) begin
        if (end_of_message) total <= '0;
        else total <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) blk <= {blk[BLOCK_BITS-9:0], wr_byte};
    if (accept && end_of_message) len <= {total_inc, 3'b000};
    else if (state == FRONT_LEN && emit) len <= {len[55:0], 8'h00};
  end

endmodule

### design/sha256_queue.sv
// short block queue between the front end and the compression core
module sha256_queue import sha256_pkg::*; #(
  parameter int Depth = SHA_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  logic   pop,
  output block_t head,
  output logic   full,
  output logic   empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  block_t            mem [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (do_push && !do_pop) count <= count + CntW'(1);
      else if (do_pop && !do_push) count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.entry;
  end

endmodule

### design/sha256_core.sv
// compression core: one round per cycle, chaining words and digest register
module sha256_core import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  block_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [63:0] digest_part_3,
  output logic [63:0] digest_part_2,
  output logic [63:0] digest_part_1,
  output logic [63:0] digest_part_0
);

  core_state_t state, state_next;
  logic [5:0]  round;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic        last_blk;

  logic        finish_go;
  logic [31:0] t1, t2, w_new, ch, maj;
  logic [31:0] sums [8];

  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + big_sigma1(v[4]) + ch + ROUND_K[round] + w[0];
  assign t2    = big_sigma0(v[0]) + maj;
  assign w_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];

  always_comb begin
    for (int i = 0; i < 8; i++) sums[i] = h[i] + v[i];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: begin
        if (!empty) state_next = CORE_ROUND;
      end
      CORE_ROUND: begin
        if (round == LAST_ROUND) state_next = CORE_FINISH;
      end
      CORE_FINISH: begin
        if (!(last_blk && dig_valid && dig_stall)) state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    finish_go = 1'b0;
    case (state)
      CORE_IDLE:   pop = !empty;
      CORE_ROUND:  pop = 1'b0;
      CORE_FINISH: finish_go = !(last_blk && dig_valid && dig_stall);
      default:     pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CORE_IDLE;
      round     <= '0;
      dig_valid <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else begin
      state <= state_next;
      if (pop) round <= '0;
      else if (state == CORE_ROUND) round <= round + 6'd1;
      if (finish_go && last_blk) dig_valid <= 1'b1;
      else if (!dig_stall) dig_valid <= 1'b0;
      if (finish_go) begin
        for (int i = 0; i < 8; i++) h[i] <= last_blk ? INIT_H[i] : sums[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_blk <= head.last;
      for (int i = 0; i < 8; i++) v[i] <= h[i];
      for (int i = 0; i < 16; i++) w[i] <= head.data[BLOCK_BITS-1-32*i -: 32];
    end else if (state == CORE_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
    if (finish_go && last_blk) begin
      digest_part_3 <= {sums[0], sums[1]};
      digest_part_2 <= {sums[2], sums[3]};
      digest_part_1 <= {sums[4], sums[5]};
      digest_part_0 <= {sums[6], sums[7]};
    end
  end

endmodule

### design/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher
//
// message channel: one transaction per byte (msg_valid / msg_stall). a
//   transaction with byte_present low and end_of_message low does nothing; one
//   with end_of_message high closes the message after its byte (if any)
// digest channel: one transaction per message (dig_valid / dig_stall) carries
//   the 256-bit digest in four 64-bit big-endian parts, part 3 first
// throughput: one byte per cycle while the block queue has room and no padding
//   is being written; the compression core takes one block at a time (load,
//   64 rounds, chaining add), so on long messages the round unit sets the pace
// after end of message: the front end writes the padding and length bytes (9
//   to 72 of them) while msg_stall is high, then the final block or two pass
//   the queue and core; the digest is registered with dig_valid in the
//   chaining-add step of the last block
// reset: synchronous, clears the byte count, the queue and all handshakes and
//   loads the initial hash values
// receiver stall: the digest register holds; the core keeps a following message's
//   last block until the digest is taken; the queue fills, stalling the bytes
module sha256_stream_hasher_top import sha256_pkg::*; #(
  parameter int QueueDepth = SHA_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  message_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [63:0] digest_part_3,
  output logic [63:0] digest_part_2,
  output logic [63:0] digest_part_1,
  output logic [63:0] digest_part_0
);

  push_t  push;
  block_t head;
  logic   q_full, q_empty, pop;

  // byte gathering and padding
  sha256_front u_front (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_stall      (msg_stall),
    .message_byte   (message_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .push           (push)
  );

  // finished blocks wait here so padding and compression overlap
  sha256_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // round unit, chaining words and digest output register
  sha256_core u_core (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .dig_valid     (dig_valid),
    .dig_stall     (dig_stall),
    .digest_part_3 (digest_part_3),
    .digest_part_2 (digest_part_2),
    .digest_part_1 (digest_part_1),
    .digest_part_0 (digest_part_0)
  );

endmodule
